[design/orbp_pkg.sv]
// Package for the overwrite ring buffer with peek.
// Holds the operation codes, field widths and the result status struct.
// No dependencies.
`default_nettype none

package orbp_pkg;

  localparam int OP_W   = 2;
  localparam int BYTE_W = 8;
  localparam int AMT_W  = 12;
  localparam int FILL_W = 12;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_PEEK   = 2'd1,
    OP_SKIP   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  // status of one result word, apart from the byte read from the store
  typedef struct packed {
    logic              peek_hit;
    logic              out_of_range;
    logic              dropped_oldest;
    logic [FILL_W-1:0] fill_level;
    logic [FILL_W-1:0] free_space;
  } res_meta_t;

endpackage

`default_nettype wire

[design/orbp_if.sv]
// Valid/ready channel interfaces for the ring buffer: command words in,
// result words out. Depends on orbp_pkg for the field widths.
`default_nettype none

interface orbp_in_if;
  logic                       valid;
  logic                       ready;
  logic [orbp_pkg::OP_W-1:0]   op;
  logic [orbp_pkg::BYTE_W-1:0] byte_in;
  logic [orbp_pkg::AMT_W-1:0]  amount;

  modport source(output valid, output op, output byte_in, output amount, input ready);
  modport sink(input valid, input op, input byte_in, input amount, output ready);
endinterface

interface orbp_out_if;
  logic                       valid;
  logic                       ready;
  logic [orbp_pkg::BYTE_W-1:0] byte_out;
  logic                       out_of_range;
  logic                       dropped_oldest;
  logic [orbp_pkg::FILL_W-1:0] fill_level;
  logic [orbp_pkg::FILL_W-1:0] free_space;

  modport source(output valid, output byte_out, output out_of_range,
                 output dropped_oldest, output fill_level, output free_space,
                 input ready);
  modport sink(input valid, input byte_out, input out_of_range,
               input dropped_oldest, input fill_level, input free_space,
               output ready);
endinterface

`default_nettype wire

[design/overwrite_ring_buffer_with_peek_top.sv]
// Overwrite-oldest ring buffer with peek: top level.
// A result word is registered and becomes valid in the cycle after its command word is taken.
// Throughput: one word per cycle when not stalled; the single port of the
// byte store serves either the append write or the peek read of each word.
// Reset clears both pointers and the output valid; the store is not cleared.
// Depends on orbp_pkg, orbp_if, orbp_mem and orbp_ctrl.
`default_nettype none

module overwrite_ring_buffer_with_peek_top #(
  parameter int DEPTH = 4096
) (
  input wire logic clk,
  input wire logic rst_n,
  orbp_in_if.sink  in_ch,
  orbp_out_if.source out_ch
);

  localparam int PW = $clog2(DEPTH);

  logic                        accept;
  logic                        mem_we;
  logic                        mem_re;
  logic [PW-1:0]               mem_addr;
  logic [orbp_pkg::BYTE_W-1:0] mem_wdata;
  logic [orbp_pkg::BYTE_W-1:0] mem_rdata;
  orbp_pkg::res_meta_t         meta;
  orbp_pkg::res_meta_t         meta_r;
  logic                        ov_r;

  // output register frees up in the same cycle it is taken
  assign in_ch.ready = !ov_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  orbp_ctrl #(
    .DEPTH(DEPTH),
    .PW   (PW)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .op       (in_ch.op),
    .byte_in  (in_ch.byte_in),
    .amount   (in_ch.amount),
    .mem_we   (mem_we),
    .mem_re   (mem_re),
    .mem_addr (mem_addr),
    .mem_wdata(mem_wdata),
    .meta     (meta)
  );

  orbp_mem #(
    .DEPTH(DEPTH),
    .AW   (PW)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .re   (mem_re),
    .addr (mem_addr),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (accept) begin
      ov_r <= 1'b1;
    end else if (out_ch.ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      meta_r <= meta;
    end
  end

  // read data register only loads on a taken peek, so it holds while stalled
  assign out_ch.valid          = ov_r;
  assign out_ch.byte_out       = meta_r.peek_hit ? mem_rdata : '0;
  assign out_ch.out_of_range   = meta_r.out_of_range;
  assign out_ch.dropped_oldest = meta_r.dropped_oldest;
  assign out_ch.fill_level     = meta_r.fill_level;
  assign out_ch.free_space     = meta_r.free_space;

endmodule

`default_nettype wire

[design/orbp_mem.sv]
// Single-port byte store with registered read data.
// Depends on orbp_pkg for the byte width.
`default_nettype none

module orbp_mem #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic                        re,
  input  wire logic [AW-1:0]               addr,
  input  wire logic [orbp_pkg::BYTE_W-1:0] wdata,
  output logic      [orbp_pkg::BYTE_W-1:0] rdata
);

  logic [orbp_pkg::BYTE_W-1:0] store [DEPTH];
  logic [orbp_pkg::BYTE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      store[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= store[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[design/orbp_ctrl.sv]
// Pointer unit: holds read/write pointers, decodes each accepted word,
// drives the store port and builds the result status. Depends on orbp_pkg.
`default_nettype none

module orbp_ctrl #(
  parameter int DEPTH = 4096,
  parameter int PW    = 12
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        accept,
  input  wire logic [orbp_pkg::OP_W-1:0]   op,
  input  wire logic [orbp_pkg::BYTE_W-1:0] byte_in,
  input  wire logic [orbp_pkg::AMT_W-1:0]  amount,
  output logic                             mem_we,
  output logic                             mem_re,
  output logic      [PW-1:0]               mem_addr,
  output logic      [orbp_pkg::BYTE_W-1:0] mem_wdata,
  output orbp_pkg::res_meta_t              meta
);

  localparam int MW = (PW > orbp_pkg::AMT_W) ? PW
                    : ((orbp_pkg::AMT_W > orbp_pkg::FILL_W) ? orbp_pkg::AMT_W
                                                            : orbp_pkg::FILL_W);
  localparam logic [PW-1:0] DEPTH_P = PW'(DEPTH);
  localparam logic [PW:0]   DEPTH_W = (PW+1)'(DEPTH);
  localparam logic [PW-1:0] LAST    = PW'(DEPTH - 1);

  logic [PW-1:0] rp_r, rp_nxt;
  logic [PW-1:0] wp_r, wp_nxt;

  logic [PW-1:0] held;
  logic [MW-1:0] held_m, amt_m;
  logic [PW-1:0] wp_inc, rp_inc;
  logic [PW-1:0] skip_n, off;
  logic [PW:0]   sum, sum_adj;
  logic [PW-1:0] rp_add;
  logic [PW-1:0] fill, free;
  logic [MW-1:0] fill_m, free_m;
  orbp_pkg::op_t op_e;

  // distance modulo DEPTH, computed modulo 2^PW; true value is below DEPTH
  assign held   = wp_r - rp_r + ((wp_r < rp_r) ? DEPTH_P : '0);
  assign held_m = MW'(held);
  assign amt_m  = MW'(amount);
  assign wp_inc = (wp_r == LAST) ? '0 : wp_r + 1'b1;
  assign rp_inc = (rp_r == LAST) ? '0 : rp_r + 1'b1;
  assign skip_n = (amt_m > held_m) ? held : amt_m[PW-1:0];
  assign op_e   = orbp_pkg::op_t'(op);
  assign off    = (op_e == orbp_pkg::OP_PEEK) ? amt_m[PW-1:0] : skip_n;
  // offset is below DEPTH, so one conditional subtract wraps the sum
  assign sum     = {1'b0, rp_r} + {1'b0, off};
  assign sum_adj = sum - DEPTH_W;
  assign rp_add  = (sum >= DEPTH_W) ? sum_adj[PW-1:0] : sum[PW-1:0];

  always_comb begin
    rp_nxt              = rp_r;
    wp_nxt              = wp_r;
    mem_we              = 1'b0;
    mem_re              = 1'b0;
    mem_addr            = wp_r;
    fill                = held;
    meta.peek_hit       = 1'b0;
    meta.out_of_range   = 1'b0;
    meta.dropped_oldest = 1'b0;
    case (op_e)
      orbp_pkg::OP_APPEND: begin
        mem_we = accept;
        wp_nxt = wp_inc;
        if (wp_inc == rp_r) begin
          rp_nxt              = rp_inc;
          meta.dropped_oldest = 1'b1;
        end else begin
          fill = held + 1'b1;
        end
      end
      orbp_pkg::OP_PEEK: begin
        if (amt_m >= held_m) begin
          meta.out_of_range = 1'b1;
        end else begin
          meta.peek_hit = 1'b1;
          mem_re        = accept;
          mem_addr      = rp_add;
        end
      end
      orbp_pkg::OP_SKIP: begin
        rp_nxt = rp_add;
        fill   = held - skip_n;
      end
      orbp_pkg::OP_CLEAR: begin
        rp_nxt = '0;
        wp_nxt = '0;
        fill   = '0;
      end
      default: begin
        fill = held;
      end
    endcase
    free            = LAST - fill;
    fill_m          = MW'(fill);
    free_m          = MW'(free);
    meta.fill_level = fill_m[orbp_pkg::FILL_W-1:0];
    meta.free_space = free_m[orbp_pkg::FILL_W-1:0];
  end

  assign mem_wdata = byte_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r <= '0;
      wp_r <= '0;
    end else if (accept) begin
      rp_r <= rp_nxt;
      wp_r <= wp_nxt;
    end
  end

endmodule

`default_nettype wire
